[hdl/hslrgb_pkg.sv]
// Shared constants, codes and stage types of the HSL to RGB565 converter.
package hslrgb_pkg;

   localparam int FRAC_BITS = 8;
   localparam int FIELD_W = 9;

   localparam int HUE_SECTOR = 60;
   localparam int HUE_PAIR = 120;
   localparam int HUE_LIMIT = 360;
   localparam int WEIGHT_W = 6;

   // Width of 1-|2L-1| in units of 2^-FRAC_BITS, signed.
   localparam int DIFF_W = ((FRAC_BITS > 10) ? FRAC_BITS : 10) + 3;
   // Width of chroma in units of 2^-(2*FRAC_BITS), signed.
   localparam int CHROMA_W = DIFF_W + FIELD_W + 1;
   // Width of the channel sums in units of 1/(120*2^(2*FRAC_BITS)), signed.
   localparam int VAL_BASE_W = ((CHROMA_W + 8 > 2 * FRAC_BITS + 8) ?
                                CHROMA_W + 8 : 2 * FRAC_BITS + 8);
   localparam int VAL_W = ((VAL_BASE_W > FRAC_BITS + FIELD_W + 8) ?
                           VAL_BASE_W : FRAC_BITS + FIELD_W + 8) + 2;

   localparam logic signed [DIFF_W-1:0] DIFF_ONE = DIFF_W'(1 << FRAC_BITS);
   localparam logic signed [VAL_W-1:0] K120 = VAL_W'(120);
   localparam logic signed [VAL_W-1:0] K60 = VAL_W'(60);

   // Full scale of a channel divided by its scale is 15*2^shift.
   localparam int RB_SHIFT = 2 * FRAC_BITS - 2;
   localparam int G_SHIFT = 2 * FRAC_BITS - 3;
   localparam int RB_W = 5;
   localparam int G_W = 6;
   localparam int RB_MAX = 31;
   localparam int G_MAX = 63;
   localparam int RB_LIMIT = (RB_MAX + 1) * 15;
   localparam int G_LIMIT = (G_MAX + 1) * 15;
   localparam int T_W = 10;
   // floor(t/15) equals (t*2185)>>15 for every t below 960.
   localparam int RECIP = 2185;
   localparam int RECIP_W = 12;
   localparam int RECIP_SHIFT = 15;
   localparam int PIXEL_W = 16;
   localparam int RED_POS = 11;
   localparam int GREEN_POS = 5;

   // Pipeline depth from accepted request to the result strobe.
   localparam int LATENCY = 6;

   typedef enum logic [2:0] {
      SEC_R_Y = 3'd0,
      SEC_Y_G = 3'd1,
      SEC_G_C = 3'd2,
      SEC_C_B = 3'd3,
      SEC_B_M = 3'd4,
      SEC_M_R = 3'd5
   } sector_type;

   typedef struct packed {
      logic                     valid;
      logic                     hue_err;
      sector_type               sector;
      logic [WEIGHT_W-1:0]      weight;
      logic [FIELD_W-1:0]       lightness;
      logic signed [CHROMA_W-1:0] chroma;
   } chroma_type;

   typedef struct packed {
      logic                     valid;
      logic                     hue_err;
      logic signed [VAL_W-1:0]  red;
      logic signed [VAL_W-1:0]  green;
      logic signed [VAL_W-1:0]  blue;
   } chan_type;

endpackage

[hdl/hsl_to_rgb565_converter_top.sv]
// Top level of the HSL to RGB565 pixel converter.
//
// This block turns one HSL colour into one RGB565 pixel word per transfer and
// takes a new request in every clock cycle. A request transfers at a rising edge
// where start is high and busy is low; busy is high only while reset is held.
// Each request yields exactly one result six cycles later: rsp_strobe is high
// for a single cycle with rsp_pixel_color and rsp_hue_error, and the receiver
// must take it then, since results cannot be held off. The latency is set by
// the six register stages: sector and lightness term, chroma multiply, the
// C, X and m products, sector permutation and offset add, truncation and
// clamping, and the divide-by-fifteen reciprocal multiply with packing.
// Hue is in whole degrees; a hue of 360 or more raises rsp_hue_error and gives
// a pixel of zero. Saturation and lightness are fractions in units of 1/256
// and values above 1.0 are used as given. Each channel is truncated toward
// zero and saturated to 31 for red and blue and 63 for green.
module hsl_to_rgb565_converter_top
   import hslrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FIELD_W-1:0] req_hue_degrees,
   input  logic [FIELD_W-1:0] req_saturation,
   input  logic [FIELD_W-1:0] req_lightness,
   output logic               rsp_strobe,
   output logic [PIXEL_W-1:0] rsp_pixel_color,
   output logic               rsp_hue_error
);

   chroma_type chroma;
   chan_type   chan;
   logic       req_transfer;

   // The pipeline never stalls, so the only time a request is refused is reset.
   assign busy = reset;
   assign req_transfer = start & ~busy;

   hslrgb_chroma u_chroma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_transfer),
      .hue        (req_hue_degrees),
      .saturation (req_saturation),
      .lightness  (req_lightness),
      .chroma_out (chroma)
   );

   // All terms share the denominator 120*2^16, so no rounding happens here.
   hslrgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .chroma_in (chroma),
      .chan_out  (chan)
   );

   hslrgb_quant u_quant (
      .clock      (clock),
      .reset      (reset),
      .chan_in    (chan),
      .out_strobe (rsp_strobe),
      .out_pixel  (rsp_pixel_color),
      .out_err    (rsp_hue_error)
   );

endmodule

[hdl/hslrgb_chroma.sv]
// Stages one and two: hue sector and weight, then chroma = (1-|2L-1|)*S.
module hslrgb_chroma
   import hslrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [FIELD_W-1:0] hue,
   input  logic [FIELD_W-1:0] saturation,
   input  logic [FIELD_W-1:0] lightness,
   output chroma_type         chroma_out
);

   sector_type               sector_in, sector_ff;
   logic                     err_in, err_ff, valid_ff;
   logic [FIELD_W-1:0]       base, rem, rem_up;
   logic [WEIGHT_W-1:0]      weight_in, weight_ff;
   logic signed [DIFF_W-1:0] dev, mag, diff_in, diff_ff;
   logic [FIELD_W-1:0]       sat_ff, lig_ff;
   chroma_type               chroma_in, chroma_ff;

   always_comb begin
      err_in = (hue >= FIELD_W'(HUE_LIMIT));
      priority if (hue >= FIELD_W'(5 * HUE_SECTOR)) sector_in = SEC_M_R;
      else if (hue >= FIELD_W'(4 * HUE_SECTOR)) sector_in = SEC_B_M;
      else if (hue >= FIELD_W'(3 * HUE_SECTOR)) sector_in = SEC_C_B;
      else if (hue >= FIELD_W'(2 * HUE_SECTOR)) sector_in = SEC_G_C;
      else if (hue >= FIELD_W'(HUE_SECTOR)) sector_in = SEC_Y_G;
      else sector_in = SEC_R_Y;
      unique case (sector_in)
         SEC_R_Y, SEC_Y_G: base = '0;
         SEC_G_C, SEC_C_B: base = FIELD_W'(HUE_PAIR);
         SEC_B_M, SEC_M_R: base = FIELD_W'(2 * HUE_PAIR);
         default: base = '0;
      endcase
      // Weight is 60 at the middle of a sector pair and falls to 0 at its ends.
      rem = hue - base;
      rem_up = FIELD_W'(HUE_PAIR) - rem;
      weight_in = (rem < FIELD_W'(HUE_SECTOR)) ? rem[WEIGHT_W-1:0] : rem_up[WEIGHT_W-1:0];
      dev = $signed({{(DIFF_W-FIELD_W-1){1'b0}}, lightness, 1'b0}) - DIFF_ONE;
      mag = (dev < 0) ? -dev : dev;
      diff_in = DIFF_ONE - mag;
   end

   always_comb begin
      chroma_in.valid = valid_ff;
      chroma_in.hue_err = err_ff;
      chroma_in.sector = sector_ff;
      chroma_in.weight = weight_ff;
      chroma_in.lightness = lig_ff;
      chroma_in.chroma = CHROMA_W'(diff_ff) * $signed({1'b0, sat_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         chroma_ff.valid <= 1'b0;
      end else begin
         valid_ff <= in_valid;
         chroma_ff.valid <= chroma_in.valid;
      end
      chroma_ff.hue_err <= chroma_in.hue_err;
      chroma_ff.sector <= chroma_in.sector;
      chroma_ff.weight <= chroma_in.weight;
      chroma_ff.lightness <= chroma_in.lightness;
      chroma_ff.chroma <= chroma_in.chroma;
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      sector_ff <= sector_in;
      weight_ff <= weight_in;
      diff_ff <= diff_in;
      sat_ff <= saturation;
      lig_ff <= lightness;
   end

   assign chroma_out = chroma_ff;

endmodule

[hdl/hslrgb_mix.sv]
// Stages three and four: C, X and m terms, then the sector permutation plus m.
module hslrgb_mix
   import hslrgb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  chroma_type chroma_in,
   output chan_type   chan_out
);

   logic signed [VAL_W-1:0] chroma_x, lig_x;
   logic signed [VAL_W-1:0] cv_in, xv_in, mv_in, cv_ff, xv_ff, mv_ff;
   logic signed [VAL_W-1:0] rsel, gsel, bsel;
   logic                    valid_ff, err_ff;
   sector_type              sector_ff;
   chan_type                chan_in, chan_ff;

   always_comb begin
      chroma_x = VAL_W'(chroma_in.chroma);
      lig_x = $signed(VAL_W'({chroma_in.lightness, {FRAC_BITS{1'b0}}}));
      cv_in = chroma_x * K120;
      xv_in = chroma_x * $signed(VAL_W'({chroma_in.weight, 1'b0}));
      mv_in = lig_x * K120 - chroma_x * K60;
   end

   always_comb begin
      unique case (sector_ff)
         SEC_R_Y: begin rsel = cv_ff; gsel = xv_ff; bsel = '0;    end
         SEC_Y_G: begin rsel = xv_ff; gsel = cv_ff; bsel = '0;    end
         SEC_G_C: begin rsel = '0;    gsel = cv_ff; bsel = xv_ff; end
         SEC_C_B: begin rsel = '0;    gsel = xv_ff; bsel = cv_ff; end
         SEC_B_M: begin rsel = xv_ff; gsel = '0;    bsel = cv_ff; end
         default: begin rsel = cv_ff; gsel = '0;    bsel = xv_ff; end
      endcase
      chan_in.valid = valid_ff;
      chan_in.hue_err = err_ff;
      chan_in.red = rsel + mv_ff;
      chan_in.green = gsel + mv_ff;
      chan_in.blue = bsel + mv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         chan_ff.valid <= 1'b0;
      end else begin
         valid_ff <= chroma_in.valid;
         chan_ff.valid <= chan_in.valid;
      end
      chan_ff.hue_err <= chan_in.hue_err;
      chan_ff.red <= chan_in.red;
      chan_ff.green <= chan_in.green;
      chan_ff.blue <= chan_in.blue;
   end

   always_ff @(posedge clock) begin
      err_ff <= chroma_in.hue_err;
      sector_ff <= chroma_in.sector;
      cv_ff <= cv_in;
      xv_ff <= xv_in;
      mv_ff <= mv_in;
   end

   assign chan_out = chan_ff;

endmodule

[hdl/hslrgb_quant.sv]
// Stages five and six: truncate, clamp and divide by fifteen, then pack RGB565.
module hslrgb_quant
   import hslrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  chan_type           chan_in,
   output logic               out_strobe,
   output logic [PIXEL_W-1:0] out_pixel,
   output logic               out_err
);

   localparam int PROD_W = T_W + RECIP_W;

   typedef struct packed {
      logic           zero;
      logic           sat;
      logic [T_W-1:0] t;
   } pre_type;

   function automatic pre_type quant_pre(input logic signed [VAL_W-1:0] v,
                                         input int shift, input int limit);
      logic [VAL_W-1:0] t;
      pre_type          p;
      t = $unsigned(v) >> shift;
      p.zero = (v <= 0);
      p.sat = (t >= VAL_W'(limit));
      p.t = t[T_W-1:0];
      return p;
   endfunction

   pre_type              red_in, green_in, blue_in, red_ff, green_ff, blue_ff;
   logic                 valid_ff, err_ff;
   logic [PROD_W-1:0]    red_prod, green_prod, blue_prod;
   logic [RB_W-1:0]      red_q, blue_q;
   logic [G_W-1:0]       green_q;
   logic [PIXEL_W-1:0]   pixel_in, pixel_ff;
   logic                 strobe_ff, out_err_ff;

   always_comb begin
      red_in = quant_pre(chan_in.red, RB_SHIFT, RB_LIMIT);
      green_in = quant_pre(chan_in.green, G_SHIFT, G_LIMIT);
      blue_in = quant_pre(chan_in.blue, RB_SHIFT, RB_LIMIT);
   end

   always_comb begin
      red_prod = PROD_W'(red_ff.t) * PROD_W'(RECIP);
      green_prod = PROD_W'(green_ff.t) * PROD_W'(RECIP);
      blue_prod = PROD_W'(blue_ff.t) * PROD_W'(RECIP);
      priority if (red_ff.zero) red_q = '0;
      else if (red_ff.sat) red_q = RB_W'(RB_MAX);
      else red_q = red_prod[RECIP_SHIFT +: RB_W];
      priority if (green_ff.zero) green_q = '0;
      else if (green_ff.sat) green_q = G_W'(G_MAX);
      else green_q = green_prod[RECIP_SHIFT +: G_W];
      priority if (blue_ff.zero) blue_q = '0;
      else if (blue_ff.sat) blue_q = RB_W'(RB_MAX);
      else blue_q = blue_prod[RECIP_SHIFT +: RB_W];
      if (err_ff) begin
         pixel_in = '0;
      end else begin
         pixel_in = (PIXEL_W'(red_q) << RED_POS) | (PIXEL_W'(green_q) << GREEN_POS)
                  | PIXEL_W'(blue_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff <= chan_in.valid;
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= chan_in.hue_err;
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      pixel_ff <= pixel_in;
      out_err_ff <= err_ff;
   end

   assign out_strobe = strobe_ff;
   assign out_pixel = pixel_ff;
   assign out_err = out_err_ff;

endmodule

[hdl/hslrgb_checker.sv]
// Port-level assertions of the HSL to RGB565 converter and their bind.
module hslrgb_checker
   import hslrgb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [FIELD_W-1:0] req_hue_degrees,
   input logic [FIELD_W-1:0] req_lightness,
   input logic               rsp_strobe,
   input logic [PIXEL_W-1:0] rsp_pixel_color,
   input logic               rsp_hue_error
);

   logic req_transfer;
   assign req_transfer = start & ~busy;

   // Every transfer produces a strobe after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_transfer |-> ##LATENCY rsp_strobe)
      else $error("missing result after a request transfer");

   // No strobe appears without a matching request.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_transfer, LATENCY))
      else $error("result strobe without a request");

   // The error flag follows the hue of the matching request.
   a_hue_err: assert property (@(posedge clock) disable iff (reset)
      req_transfer |-> ##LATENCY
         (rsp_hue_error == ($past(req_hue_degrees, LATENCY) >= FIELD_W'(HUE_LIMIT))))
      else $error("hue error flag does not match the request");

   // An error result carries a black pixel.
   a_err_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hue_error) |-> (rsp_pixel_color == '0))
      else $error("error result with a nonzero pixel");

   // Zero lightness always gives black.
   a_dark: assert property (@(posedge clock) disable iff (reset)
      (req_transfer && (req_lightness == '0)) |-> ##LATENCY (rsp_pixel_color == '0))
      else $error("zero lightness gave a nonzero pixel");

endmodule

bind hsl_to_rgb565_converter_top hslrgb_checker u_hslrgb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_hue_degrees (req_hue_degrees),
   .req_lightness   (req_lightness),
   .rsp_strobe      (rsp_strobe),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_hue_error   (rsp_hue_error)
);
